/* hw/rtl/stwf_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Short-term window features: shared definitions
// Widths, window limits and the record types passed between the stages.
// ----------------------------------------------------------------------------
package stwf_pkg;

   // Sample and window limits
   localparam int SAMPLE_BITS = 16;
   localparam int MAX_WINDOW  = 4096;
   localparam int HIST_DEPTH  = MAX_WINDOW + 1;
   localparam int ADDR_W      = $clog2(HIST_DEPTH);
   localparam int CNT_W       = $clog2(MAX_WINDOW + 1);

   // Register and result field widths
   localparam int LEN_W    = 13;
   localparam int SUM_W    = 28;
   localparam int ENERGY_W = 43;
   localparam int MAG_W    = 28;
   localparam int CROSS_W  = 13;
   localparam int FIG_W    = SUM_W + ENERGY_W + MAG_W + CROSS_W;

   localparam logic [LEN_W-1:0] WINDOW_RESET = LEN_W'(2400);

   // One set of figures: a prefix total or a window total
   typedef struct packed {
      logic [SUM_W-1:0]    sum;
      logic [ENERGY_W-1:0] energy;
      logic [MAG_W-1:0]    mag;
      logic [CROSS_W-1:0]  crossings;
   } figures_type;

   // How the window is formed from the two prefix totals
   typedef struct packed {
      logic zero_window;
      logic subtract;
   } window_ctl_type;

endpackage
`default_nettype wire

/* hw/rtl/stwf_ram.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module stwf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

/* hw/rtl/stwf_prefix.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Short-term window features: prefix stage
// Keeps the running prefix totals of the current signal, stores each one in
// the history RAM and looks up the prefix that lies one window back.
// ----------------------------------------------------------------------------
module stwf_prefix (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  advance,
   input  logic signed [stwf_pkg::SAMPLE_BITS-1:0] sample,
   input  logic                                  first_of_signal,
   input  logic [stwf_pkg::LEN_W-1:0]            window_length,
   output logic                                  mem_wr_en,
   output logic [stwf_pkg::ADDR_W-1:0]           mem_wr_addr,
   output stwf_pkg::figures_type                 mem_wr_data,
   output logic                                  mem_rd_en,
   output logic [stwf_pkg::ADDR_W-1:0]           mem_rd_addr,
   output stwf_pkg::figures_type                 prefix,
   output stwf_pkg::window_ctl_type              ctl
);
   import stwf_pkg::*;

   localparam logic [ADDR_W:0] DEPTH_EXT = (ADDR_W + 1)'(HIST_DEPTH);
   localparam logic [ADDR_W-1:0] LAST_POS = ADDR_W'(HIST_DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_WINDOW);
   localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_WINDOW);

   logic [ADDR_W-1:0]      pos_ff, pos_in;
   logic [CNT_W-1:0]       idx_ff, idx_in;
   logic                   prev_pos_ff, prev_pos_in;
   figures_type            prefix_ff, prefix_in;
   window_ctl_type         ctl_ff, ctl_in;

   logic [ADDR_W-1:0]      pos_cur;
   logic [CNT_W-1:0]       idx_cur;
   logic [LEN_W-1:0]       len_eff;
   logic [SAMPLE_BITS-1:0] abs_val;
   logic [2*SAMPLE_BITS-1:0] square;
   logic                   positive;
   logic                   cross_inc;
   figures_type            base;
   logic [ADDR_W:0]        rd_diff;
   logic [ADDR_W:0]        rd_wrap;

   // Position and index of this sample inside its signal
   assign pos_cur = first_of_signal ? '0 : pos_ff;
   assign idx_cur = first_of_signal ? '0 : idx_ff;
   assign len_eff = (window_length > LEN_MAX) ? LEN_MAX : window_length;

   // Per-sample contributions
   assign abs_val   = sample[SAMPLE_BITS-1] ? $unsigned(~sample + 1'b1) : $unsigned(sample);
   assign square    = abs_val * abs_val;
   assign positive  = !sample[SAMPLE_BITS-1] && (|sample);
   assign cross_inc = (idx_cur != '0) && (positive != prev_pos_ff);
   assign base      = (idx_cur == '0) ? '0 : prefix_ff;

   always_comb begin
      prefix_in.sum       = base.sum
                          + {{(SUM_W - SAMPLE_BITS){sample[SAMPLE_BITS-1]}}, sample};
      prefix_in.energy    = base.energy + ENERGY_W'(square);
      prefix_in.mag       = base.mag + MAG_W'(abs_val);
      prefix_in.crossings = base.crossings + CROSS_W'(cross_inc);
   end

   // Address of the prefix one window back, modulo the history depth
   assign rd_diff = (ADDR_W + 1)'(pos_cur) - (ADDR_W + 1)'(len_eff);
   assign rd_wrap = rd_diff[ADDR_W] ? (rd_diff + DEPTH_EXT) : rd_diff;

   assign ctl_in.zero_window = (len_eff == '0);
   assign ctl_in.subtract    = (CNT_W'(idx_cur) >= CNT_W'(len_eff));

   // Next position and saturating index
   assign pos_in      = (pos_cur == LAST_POS) ? '0 : pos_cur + 1'b1;
   assign idx_in      = (idx_cur == CNT_MAX) ? idx_cur : idx_cur + 1'b1;
   assign prev_pos_in = positive;

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
         idx_ff <= '0;
      end else if (advance) begin
         pos_ff <= pos_in;
         idx_ff <= idx_in;
      end
   end

   // Stage payload
   always_ff @(posedge clock) begin
      if (advance) begin
         prev_pos_ff <= prev_pos_in;
         prefix_ff   <= prefix_in;
         ctl_ff      <= ctl_in;
      end
   end

   assign mem_wr_en   = advance;
   assign mem_wr_addr = pos_cur;
   assign mem_wr_data = prefix_in;
   assign mem_rd_en   = advance;
   assign mem_rd_addr = rd_wrap[ADDR_W-1:0];
   assign prefix      = prefix_ff;
   assign ctl         = ctl_ff;

endmodule
`default_nettype wire

/* hw/rtl/stwf_window.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Short-term window features: window stage
// Forms the window totals as the difference of two prefix totals (the prefix
// alone early in a signal, zero for an empty window) and holds them in the result register.
// ----------------------------------------------------------------------------
module stwf_window (
   input  logic                               clock,
   input  logic                               load,
   input  stwf_pkg::figures_type              prefix,
   input  stwf_pkg::figures_type              prefix_old,
   input  stwf_pkg::window_ctl_type           ctl,
   output logic signed [stwf_pkg::SUM_W-1:0]  window_sum,
   output logic [stwf_pkg::ENERGY_W-1:0]      window_energy,
   output logic [stwf_pkg::MAG_W-1:0]         window_magnitude,
   output logic [stwf_pkg::CROSS_W-1:0]       crossing_count
);
   import stwf_pkg::*;

   figures_type win_ff, win_in;

   // Window totals; modular differences are exact at the field widths
   always_comb begin
      if (ctl.zero_window) begin
         win_in = '0;
      end else if (ctl.subtract) begin
         win_in.sum       = prefix.sum - prefix_old.sum;
         win_in.energy    = prefix.energy - prefix_old.energy;
         win_in.mag       = prefix.mag - prefix_old.mag;
         win_in.crossings = prefix.crossings - prefix_old.crossings;
      end else begin
         win_in = prefix;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         win_ff <= win_in;
      end
   end

   assign window_sum       = $signed(win_ff.sum);
   assign window_energy    = win_ff.energy;
   assign window_magnitude = win_ff.mag;
   assign crossing_count   = win_ff.crossings;

endmodule
`default_nettype wire

/* hw/rtl/short_term_window_features_unit.sv */
`timescale 1ns / 1ps
`default_nettype none
// A sample passes the input register, the prefix stage and the result register.
// Throughput: one sample word per cycle while rsp_ready is high, set by the prefix
//   history RAM, which takes one write and one read per sample.
// Reset (synchronous, active high) empties the pipeline, starts a new signal and
//   sets the window length to 2400; no clearing pass over the history is needed.
// ----------------------------------------------------------------------------
// Short-term window features unit
// Sum, energy, magnitude and zero-crossing count over a sliding window of
// audio samples, formed from stored prefix totals of the current signal.
// ----------------------------------------------------------------------------
module short_term_window_features_unit (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_ready,
   input  logic signed [stwf_pkg::SAMPLE_BITS-1:0] req_sample,
   input  logic                                    req_first_of_signal,
   output logic                                    rsp_valid,
   input  logic                                    rsp_ready,
   output logic signed [stwf_pkg::SUM_W-1:0]       rsp_window_sum,
   output logic [stwf_pkg::ENERGY_W-1:0]           rsp_window_energy,
   output logic [stwf_pkg::MAG_W-1:0]              rsp_window_magnitude,
   output logic [stwf_pkg::CROSS_W-1:0]            rsp_crossing_count,
   input  logic                                    csr_valid,
   output logic                                    csr_ready,
   input  logic [stwf_pkg::LEN_W-1:0]              csr_window_length
);
   import stwf_pkg::*;

   logic                   s0_valid_ff, s0_valid_in;
   logic signed [SAMPLE_BITS-1:0] s0_sample_ff;
   logic                   s0_first_ff;
   logic                   s1_valid_ff, s1_valid_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [LEN_W-1:0]       window_length_ff;

   logic                   out_free;
   logic                   s1_free;
   logic                   s0_adv;
   logic                   s1_adv;
   logic                   req_take;

   logic                   mem_wr_en;
   logic [ADDR_W-1:0]      mem_wr_addr;
   figures_type            mem_wr_data;
   logic                   mem_rd_en;
   logic [ADDR_W-1:0]      mem_rd_addr;
   figures_type            mem_rd_data;
   figures_type            prefix;
   window_ctl_type         ctl;

   // Stage handshake: each stage moves when the next one is empty or moving
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign s1_adv    = s1_valid_ff && out_free;
   assign s1_free   = !s1_valid_ff || out_free;
   assign s0_adv    = s0_valid_ff && s1_free;
   assign req_ready = !s0_valid_ff || s1_free;
   assign req_take  = req_valid && req_ready;

   assign s0_valid_in  = req_take || (s0_valid_ff && !s1_free);
   assign s1_valid_in  = s0_adv || (s1_valid_ff && !out_free);
   assign rsp_valid_in = s1_adv || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff  <= 1'b0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s0_valid_ff  <= s0_valid_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Input register
   always_ff @(posedge clock) begin
      if (req_take) begin
         s0_sample_ff <= req_sample;
         s0_first_ff  <= req_first_of_signal;
      end
   end

   // Window length register
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         window_length_ff <= WINDOW_RESET;
      end else if (csr_valid) begin
         window_length_ff <= csr_window_length;
      end
   end

   stwf_prefix u_prefix (
      .clock           (clock),
      .reset           (reset),
      .advance         (s0_adv),
      .sample          (s0_sample_ff),
      .first_of_signal (s0_first_ff),
      .window_length   (window_length_ff),
      .mem_wr_en       (mem_wr_en),
      .mem_wr_addr     (mem_wr_addr),
      .mem_wr_data     (mem_wr_data),
      .mem_rd_en       (mem_rd_en),
      .mem_rd_addr     (mem_rd_addr),
      .prefix          (prefix),
      .ctl             (ctl)
   );

   // Prefix history, one entry per sample position
   stwf_ram #(
      .WIDTH (FIG_W),
      .DEPTH (HIST_DEPTH)
   ) u_history (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   stwf_window u_window (
      .clock            (clock),
      .load             (s1_adv),
      .prefix           (prefix),
      .prefix_old       (mem_rd_data),
      .ctl              (ctl),
      .window_sum       (rsp_window_sum),
      .window_energy    (rsp_window_energy),
      .window_magnitude (rsp_window_magnitude),
      .crossing_count   (rsp_crossing_count)
   );

   assign rsp_valid = rsp_valid_ff;

`ifndef SYNTH
   // Pipeline is empty right after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> (!rsp_valid && !s1_valid_ff && !s0_valid_ff))
      else $error("pipeline not empty after reset");

   // The window never holds more pairs than its maximum length
   a_cross_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_crossing_count <= CROSS_W'(MAX_WINDOW)))
      else $error("crossing count above window maximum");

   // The signed sum is bounded by the magnitude
   a_sum_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (($signed({rsp_window_sum[SUM_W-1], rsp_window_sum})
                       <= $signed({1'b0, rsp_window_magnitude}))
                  && (-$signed({rsp_window_sum[SUM_W-1], rsp_window_sum})
                       <= $signed({1'b0, rsp_window_magnitude}))))
      else $error("window sum exceeds window magnitude");

   // Integer squares never total less than the absolute values
   a_energy_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_window_energy >= ENERGY_W'(rsp_window_magnitude)))
      else $error("window energy below window magnitude");
`endif

endmodule
`default_nettype wire

/* tb/short_term_window_features_unit_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Short-term window features unit: self-checking testbench
// Drives sample words through valid/ready with random idling and back-pressure,
// rewrites the window length between phases, and compares every result word
// with a behavioral model of the windowed sum, energy, magnitude and crossing
// count. A directed table comes first, then random signals of varied length.
// ----------------------------------------------------------------------------
module short_term_window_features_unit_test;
   import stwf_pkg::*;

   localparam int TIMEOUT_NS    = 2_000_000;
   localparam int SETTLE_CYCLES = 4;
   localparam int HOLD_CYCLES   = 300;
   localparam int DIRECTED_ROWS = 23;

   localparam logic [SAMPLE_BITS-1:0] MOST_POSITIVE = 16'h7FFF;
   localparam logic [SAMPLE_BITS-1:0] MOST_NEGATIVE = 16'h8000;

   // One row of the directed table; want is used only when typed is set
   typedef struct packed {
      logic                   set_window;
      logic [LEN_W-1:0]       window;
      logic [SAMPLE_BITS-1:0] sample;
      logic                   first;
      logic                   typed;
      figures_type            want;
   } stim_row_type;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          req_valid = 1'b0;
   logic                          req_ready;
   logic signed [SAMPLE_BITS-1:0] req_sample = '0;
   logic                          req_first_of_signal = 1'b0;
   logic                          rsp_valid;
   logic                          rsp_ready = 1'b0;
   logic signed [SUM_W-1:0]       rsp_window_sum;
   logic [ENERGY_W-1:0]           rsp_window_energy;
   logic [MAG_W-1:0]              rsp_window_magnitude;
   logic [CROSS_W-1:0]            rsp_crossing_count;
   logic                          csr_valid = 1'b0;
   logic                          csr_ready;
   logic [LEN_W-1:0]              csr_window_length = '0;

   // Model state: sample history of the current signal and the window length
   logic signed [SAMPLE_BITS-1:0] past_samples [HIST_DEPTH];
   int unsigned                   next_slot = 0;
   int unsigned                   seen_count = 0;
   int unsigned                   longest_run = 0;
   logic [LEN_W-1:0]              window_cfg = WINDOW_RESET;

   figures_type expected_figures [$];

   int idle_pct = 0;
   int stall_pct = 0;
   int hold_token = 0;
   int signal_left = 0;
   int mismatch_count = 0;
   int words_sent = 0;
   int words_checked = 0;
   int windows_written = 0;

   // Directed rows: extremes, restarts, window of zero, one, 4096 and above 4096
   stim_row_type directed_rows [DIRECTED_ROWS] = '{
      // set_window, window, sample, first, typed, want {sum, energy, mag, crossings}
      '{1'b0, 13'd0,    16'h7FFF, 1'b1, 1'b1,
        '{28'd32767, 43'd1073676289, 28'd32767, 13'd0}},
      '{1'b0, 13'd0,    16'h8000, 1'b0, 1'b1,
        '{28'hFFFFFFF, 43'd2147418113, 28'd65535, 13'd1}},
      '{1'b0, 13'd0,    16'h0000, 1'b0, 1'b1,
        '{28'hFFFFFFF, 43'd2147418113, 28'd65535, 13'd1}},
      '{1'b0, 13'd0,    16'h0001, 1'b0, 1'b1,
        '{28'd0, 43'd2147418114, 28'd65536, 13'd2}},
      // restart mid-stream drops all earlier history
      '{1'b0, 13'd0,    16'hFFFF, 1'b1, 1'b1, '{28'hFFFFFFF, 43'd1, 28'd1, 13'd0}},
      '{1'b0, 13'd0,    16'h0002, 1'b0, 1'b0, '0},
      '{1'b0, 13'd0,    16'hFFFD, 1'b0, 1'b0, '0},
      '{1'b0, 13'd0,    16'h0000, 1'b0, 1'b0, '0},
      '{1'b0, 13'd0,    16'h7FFF, 1'b0, 1'b0, '0},
      // window of one sample still counts one pair
      '{1'b1, 13'd1,    16'h0064, 1'b0, 1'b0, '0},
      '{1'b0, 13'd0,    16'hFF9C, 1'b0, 1'b0, '0},
      // empty window
      '{1'b1, 13'd0,    16'hFFF9, 1'b0, 1'b1, '0},
      '{1'b0, 13'd0,    16'h7FFF, 1'b1, 1'b1, '0},
      // oversize window clamps to the history limit
      '{1'b1, 13'd8191, 16'h8000, 1'b0, 1'b0, '0},
      '{1'b0, 13'd0,    16'h7FFF, 1'b0, 1'b0, '0},
      '{1'b1, 13'd4096, 16'h8000, 1'b1, 1'b1,
        '{28'hFFF8000, 43'd1073741824, 28'd32768, 13'd0}},
      '{1'b0, 13'd0,    16'h8000, 1'b0, 1'b0, '0},
      '{1'b1, 13'd2,    16'h0001, 1'b0, 1'b0, '0},
      '{1'b0, 13'd0,    16'hFFFF, 1'b0, 1'b0, '0},
      '{1'b0, 13'd0,    16'h0000, 1'b0, 1'b0, '0},
      '{1'b1, 13'd2400, 16'h007B, 1'b1, 1'b0, '0},
      '{1'b0, 13'd0,    16'h5555, 1'b0, 1'b0, '0},
      '{1'b0, 13'd0,    16'hAAAA, 1'b0, 1'b0, '0}
   };

   short_term_window_features_unit uut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_sample           (req_sample),
      .req_first_of_signal  (req_first_of_signal),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_window_sum       (rsp_window_sum),
      .rsp_window_energy    (rsp_window_energy),
      .rsp_window_magnitude (rsp_window_magnitude),
      .rsp_crossing_count   (rsp_crossing_count),
      .csr_valid            (csr_valid),
      .csr_ready            (csr_ready),
      .csr_window_length    (csr_window_length)
   );

   always #2 clock = ~clock;

   // History slot k samples back from the newest one
   function automatic int unsigned slot_back(input int unsigned k);
      return (next_slot + HIST_DEPTH - 1 - k) % HIST_DEPTH;
   endfunction

   // Take one sample into the history and work out the figures of its window
   function automatic figures_type window_figures(input logic signed [SAMPLE_BITS-1:0] s,
                                                  input logic first);
      longint                        total = 0;
      longint                        energy_acc = 0;
      longint                        mag_acc = 0;
      longint                        mag_now;
      int unsigned                   span, used, pairs;
      int unsigned                   cross_acc = 0;
      logic signed [SAMPLE_BITS-1:0] newer, older;
      figures_type                   fig;
      if (first) begin
         seen_count = 0;
         next_slot = 0;
      end
      past_samples[next_slot] = s;
      next_slot = (next_slot + 1) % HIST_DEPTH;
      if (seen_count < HIST_DEPTH) seen_count++;
      if (seen_count > longest_run) longest_run = seen_count;

      span  = (window_cfg > MAX_WINDOW) ? MAX_WINDOW : window_cfg;
      used  = (span < seen_count) ? span : seen_count;
      pairs = (span < seen_count - 1) ? span : seen_count - 1;

      // pairs never exceeds used, so one pass covers both
      for (int unsigned k = 0; k < used; k++) begin
         newer = past_samples[slot_back(k)];
         mag_now = (newer < 0) ? -longint'(newer) : longint'(newer);
         total += newer;
         energy_acc += mag_now * mag_now;
         mag_acc += mag_now;
         if (k < pairs) begin
            older = past_samples[slot_back(k + 1)];
            if ((newer > 0) != (older > 0)) cross_acc++;
         end
      end
      fig.sum       = total[SUM_W-1:0];
      fig.energy    = energy_acc[ENERGY_W-1:0];
      fig.mag       = mag_acc[MAG_W-1:0];
      fig.crossings = cross_acc[CROSS_W-1:0];
      return fig;
   endfunction

   // Extremes and values near zero are favored so sign changes stay frequent
   function automatic logic [SAMPLE_BITS-1:0] pick_sample();
      case ($urandom_range(9))
         0:       return MOST_POSITIVE;
         1:       return MOST_NEGATIVE;
         2:       return '0;
         3, 4, 5: return SAMPLE_BITS'($urandom_range(6) - 3);
         default: return SAMPLE_BITS'($urandom);
      endcase
   endfunction

   // One line per mismatch, and a running count
   task automatic flag_mismatch(input string what);
      mismatch_count++;
      $display("%0t ns: mismatch at result word %0d: %s", $time, words_checked, what);
   endtask

   // Called at a falling edge; returns at the falling edge after acceptance
   task automatic send_word(input logic [SAMPLE_BITS-1:0] s, input logic first,
                            input logic typed, input figures_type typed_fig);
      figures_type predicted;
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         req_sample <= SAMPLE_BITS'($urandom);
         req_first_of_signal <= 1'($urandom);
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_sample <= s;
      req_first_of_signal <= first;
      do @(posedge clock); while (!req_ready);
      predicted = window_figures($signed(s), first);
      expected_figures.push_back(typed ? typed_fig : predicted);
      words_sent++;
      @(negedge clock);
   endtask

   // Stop offering, let every pending result word come back, then settle
   task automatic wait_for_results();
      req_valid <= 1'b0;
      while (expected_figures.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // Window length is only rewritten with the block idle
   task automatic next_setting(input logic [LEN_W-1:0] window);
      wait_for_results();
      csr_valid <= 1'b1;
      csr_window_length <= window;
      do @(posedge clock); while (!csr_ready);
      window_cfg = window;
      windows_written++;
      @(negedge clock);
      csr_valid <= 1'b0;
      csr_window_length <= LEN_W'($urandom);
   endtask

   // Random signals: mostly clean runs, with an occasional stray restart
   task automatic run_phase(input int items, input int idle, input int stall,
                            input int min_signal, input int max_signal, input int noise_pct);
      logic first;
      idle_pct = idle;
      stall_pct = stall;
      for (int n = 0; n < items; n++) begin
         if (signal_left == 0) begin
            first = 1'b1;
            signal_left = $urandom_range(max_signal, min_signal);
         end else begin
            first = ($urandom_range(99) < noise_pct);
         end
         signal_left--;
         send_word(pick_sample(), first, 1'b0, '0);
      end
   endtask

   // Receiver: random stalls, plus a long hold-off whenever the token moves
   always @(negedge clock) begin
      int hold_seen;
      int hold_left;
      if (hold_token != hold_seen) begin
         hold_seen = hold_token;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   // Result check against the oldest expectation
   always @(posedge clock) begin
      figures_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_figures.size() == 0) begin
            flag_mismatch("result word with no sample word pending");
         end else begin
            want = expected_figures.pop_front();
            if (rsp_window_sum !== want.sum)
               flag_mismatch($sformatf("window_sum %0d, expected %0d",
                                       rsp_window_sum, $signed(want.sum)));
            if (rsp_window_energy !== want.energy)
               flag_mismatch($sformatf("window_energy %0d, expected %0d",
                                       rsp_window_energy, want.energy));
            if (rsp_window_magnitude !== want.mag)
               flag_mismatch($sformatf("window_magnitude %0d, expected %0d",
                                       rsp_window_magnitude, want.mag));
            if (rsp_crossing_count !== want.crossings)
               flag_mismatch($sformatf("crossing_count %0d, expected %0d",
                                       rsp_crossing_count, want.crossings));
            words_checked++;
         end
      end
   end

   // Main sequence
   initial begin
      repeat (6) @(negedge clock);
      reset <= 1'b0;

      for (int i = 0; i < DIRECTED_ROWS; i++) begin
         if (directed_rows[i].set_window) next_setting(directed_rows[i].window);
         send_word(directed_rows[i].sample, directed_rows[i].first,
                   directed_rows[i].typed, directed_rows[i].want);
      end

      // each phase keeps the running signal, so the new length applies mid-signal
      next_setting(16);
      run_phase(300, 0, 0, 1, 40, 3);
      next_setting(LEN_W'($urandom_range(400, 1)));
      run_phase(300, 86, 0, 1, 800, 3);
      next_setting(1);
      run_phase(300, 0, 86, 1, 12, 5);
      next_setting(LEN_W'($urandom_range(64, 2)));
      run_phase(300, 24, 24, 1, 150, 3);

      // receiver holds off while words keep coming, so the input must stall
      next_setting(8);
      hold_token++;
      run_phase(60, 0, 0, 1, 30, 3);

      next_setting(0);
      run_phase(40, 24, 24, 1, 20, 5);

      // one long clean signal under an oversize window
      next_setting(8191);
      signal_left = 0;
      run_phase(250, 0, 0, 250, 250, 0);
      next_setting(MAX_WINDOW);
      run_phase(100, 0, 0, 1, 600, 0);

      next_setting(WINDOW_RESET);
      run_phase(130, 24, 24, 1, 600, 3);

      wait_for_results();
      $display("Checked %0d result words for %0d sample words over %0d window lengths.",
               words_checked, words_sent, windows_written);
      $display("Longest signal history held: %0d samples; mismatches: %0d.",
               longest_run, mismatch_count);
      if (mismatch_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #(TIMEOUT_NS);
      $display("Timeout with %0d result words outstanding.", expected_figures.size());
      $display("TEST FAILED");
      $finish;
   end

endmodule

/* short_term_window_features_unit.f */
hw/rtl/stwf_pkg.sv
hw/rtl/stwf_ram.sv
hw/rtl/stwf_prefix.sv
hw/rtl/stwf_window.sv
hw/rtl/short_term_window_features_unit.sv
tb/short_term_window_features_unit_test.sv
